>>> hw/rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants
// Request field widths, command codes, stream packing and the sequencer
// state type of the chained hash set.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

  localparam int KEY_W     = 32;
  localparam int CMD_W     = 2;
  localparam int BKT_OUT_W = 4;
  localparam int ENTRY_W   = KEY_W + 1;  // valid bit above the key

  // stream data widths, packed fields filled up to whole bytes
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  // remainder unit: bits consumed per cycle and cycles per key
  localparam int DIGIT_W   = 8;
  localparam int MOD_STEPS = KEY_W / DIGIT_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/chs_ram.sv
// ----------------------------------------------------------------------------
// chs_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/chs_mod.sv
// ----------------------------------------------------------------------------
// chs_mod: iterative remainder unit
// Computes key modulo DIVISOR by restoring reduction, one byte of the key
// per cycle, most significant byte first.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_mod
  import chs_pkg::*;
#(
  parameter int DIVISOR = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [KEY_W-1:0]           key,
  output logic                            done,
  output logic [$clog2(DIVISOR)-1:0]      rem
);

  localparam int REM_W = $clog2(DIVISOR);
  localparam int CNT_W = $clog2(MOD_STEPS);
  localparam logic [REM_W:0] DIV_V = (REM_W + 1)'(DIVISOR);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] shreg;
  logic [REM_W-1:0] rem_next;
  logic [REM_W:0]   trial;

  // eight dependent shift-and-subtract steps on a narrow remainder
  always_comb begin
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      trial = {rem_next, shreg[KEY_W-1-i]};
      if (trial >= DIV_V) begin
        trial = trial - DIV_V;
      end
      rem_next = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= key;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << DIGIT_W;
      rem   <= rem_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/chained_hash_set.sv
// ----------------------------------------------------------------------------
// chained_hash_set: key set in a hash table with fixed-size buckets
// Insert, find and delete of 32-bit keys; bucket = key mod BUCKETS.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on s_* (cmd, key) and one result leaves on m_*
//   (success, bucket, found_key, bucket_full), in request order.
//   The block takes one request at a time: s_tready is high only while
//   the sequencer is idle. A request passes from acceptance through the
//   byte-serial remainder unit (four bytes), a scan of the bucket's
//   BUCKET_SLOTS slots through the single read port of the key ram, a
//   write-back state, a result state and an idle state before the next
//   acceptance.
//   Results sit in an output register; if m_tready is low the sequencer
//   holds in its result cycle until the register drains, and the next
//   request can be accepted while a result still waits.
//   After reset a clearing pass writes every slot of the ram empty, one
//   slot a cycle; s_tready stays low until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_set
  import chs_pkg::*;
#(
  parameter int BUCKETS      = 10,
  parameter int BUCKET_SLOTS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // cmd[1:0], key[33:2], zero fill
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata    // success[0], bucket[4:1],
                                              // found_key[36:5], bucket_full[37]
);

  localparam int TOTAL  = BUCKETS * BUCKET_SLOTS;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int CNT_W  = $clog2(BUCKET_SLOTS + 1);
  localparam int SLOT_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;

  state_t state, state_next;

  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key;
  logic [BKT_W-1:0]  bkt;
  logic [ADDR_W-1:0] base;

  logic [ADDR_W-1:0] clr_cnt;
  logic [CNT_W-1:0]  iss_cnt;
  logic [CNT_W-1:0]  chk_cnt;
  logic              rd_vld;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;

  logic               accept;
  logic               mod_start;
  logic               mod_done;
  logic [BKT_W-1:0]   mod_rem;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               scan_last;
  logic               res_success;
  logic               res_full;
  logic [KEY_W-1:0]   res_found;
  logic               out_load;

  logic                 out_success;
  logic [BKT_OUT_W-1:0] out_bucket;
  logic [KEY_W-1:0]     out_found;
  logic                 out_full;

  assign accept    = s_tvalid && s_tready;
  assign scan_last = rd_vld && (chk_cnt == CNT_W'(BUCKET_SLOTS - 1));

  chs_mod #(
    .DIVISOR(BUCKETS)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .key  (s_tdata[CMD_W +: KEY_W]),
    .done (mod_done),
    .rem  (mod_rem)
  );

  chs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TOTAL)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // result of the finished scan
  always_comb begin
    res_success = 1'b0;
    res_full    = 1'b0;
    res_found   = '0;
    case (cmd)
      CMD_INSERT: begin
        res_success = !hit && free_found;
        res_full    = !hit && !free_found;
      end
      CMD_FIND: begin
        res_success = hit;
        res_found   = hit ? key : '0;
      end
      CMD_DELETE: begin
        res_success = hit;
      end
      default: begin
        res_success = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(TOTAL - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    mod_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = base + ADDR_W'(iss_cnt);
    out_load  = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        s_tready  = 1'b1;
        mod_start = s_tvalid;
      end
      ST_SCAN: begin
        ram_re = (iss_cnt < CNT_W'(BUCKET_SLOTS));
      end
      ST_WRITE: begin
        if (cmd == CMD_INSERT) begin
          ram_we    = !hit && free_found;
          ram_waddr = base + ADDR_W'(free_slot);
          ram_wdata = {1'b1, key};
        end else if (cmd == CMD_DELETE) begin
          ram_we    = hit;
          ram_waddr = base + ADDR_W'(hit_slot);
        end
      end
      ST_DONE: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= ram_re;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request and scan registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= s_tdata[CMD_W-1:0];
      key        <= s_tdata[CMD_W +: KEY_W];
      iss_cnt    <= '0;
      chk_cnt    <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end
    if (mod_done) begin
      bkt  <= mod_rem;
      base <= ADDR_W'(mod_rem * BUCKET_SLOTS);
    end
    if (ram_re) begin
      iss_cnt <= iss_cnt + 1'b1;
    end
    // one slot checked per cycle through the single key comparator
    if (state == ST_SCAN && rd_vld) begin
      chk_cnt <= chk_cnt + 1'b1;
      if (ram_rdata[KEY_W] && ram_rdata[KEY_W-1:0] == key && !hit) begin
        hit      <= 1'b1;
        hit_slot <= chk_cnt[SLOT_W-1:0];
      end
      if (!ram_rdata[KEY_W] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= chk_cnt[SLOT_W-1:0];
      end
    end
    if (out_load) begin
      out_success <= res_success;
      out_bucket  <= BKT_OUT_W'(bkt);
      out_found   <= res_found;
      out_full    <= res_full;
    end
  end

  assign m_tdata = {(M_DATA_W - KEY_W - BKT_OUT_W - 2)'(0),
                    out_full, out_found, out_bucket, out_success};

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == ST_MOD)
    else $error("remainder finished outside modulo state");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !ram_we)
    else $error("ram written during bucket scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result raised outside result state");

  a_full_excludes_success: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> !(res_success && res_full))
    else $error("bucket full together with success");

endmodule

`default_nettype wire
